### design/closest_point_on_triangle_top_macros.svh
`ifndef CLOSEST_POINT_ON_TRIANGLE_TOP_MACROS_SVH
`define CLOSEST_POINT_ON_TRIANGLE_TOP_MACROS_SVH

// consequent checked in the same cycle
`define CPT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cpt: same-cycle check failed");

// consequent checked in the next cycle
`define CPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cpt: next-cycle check failed");

`endif

### design/cpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int LIMB_W = 32;
endpackage

`default_nettype wire

### design/closest_point_on_triangle_top.sv
// Nearest point on triangle abc to query point p, all coordinates signed fixed point of
// COORD_WIDTH bits (any binary point, the result keeps the input format). Fully pipelined:
// one item per cycle while the skid register is empty, with the pipeline depth set mostly
// by the divider, which resolves one quotient bit per stage. Vertex, edge and
// interior regions are tested exactly on full-width products; a degenerate triangle gives
// vertex a, a zero-length edge gives its start point, and results saturate. A one-entry
// output skid register takes the result that meets a stalled receiver, so input ready comes
// from a register; while that register is full the whole pipe and the input hold.
`timescale 1ns / 1ps
`default_nettype none
`include "closest_point_on_triangle_top_macros.svh"

module closest_point_on_triangle_top #(
	parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH,
	localparam int IN_W  = ((12 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
	// vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// near_x, near_y, near_z
	output logic [OUT_W-1:0] m_tdata
);
	localparam int W    = COORD_WIDTH;
	localparam int DFW  = W + 1;
	localparam int PDW  = 2 * DFW;
	localparam int DW   = PDW + 2;
	localparam int VW   = 2 * DW + 1;
	localparam int DENW = VW + 2;
	localparam int PW   = VW + DFW;
	localparam int NW   = PW + 1;
	localparam int QK   = W + 2;
	localparam int DL   = QK + 3;
	localparam int OS   = DL + 23;
	localparam int SW   = QK + 2;
	localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] SMIN = ~SMAX;
	localparam int VA_I [6] = '{0, 2, 4, 0, 2, 4};
	localparam int VB_I [6] = '{3, 1, 1, 5, 5, 3};

	typedef struct packed {
		logic pa;
		logic pb;
		logic pc;
		logic eab;
		logic eac;
		logic ebc;
	} flag_t;

	typedef struct packed {
		logic signed [DW:0]   e1;
		logic signed [DW:0]   dab;
		logic signed [DW:0]   dac;
		logic signed [DW+1:0] dbc;
	} edg_t;

	logic en;
	logic [OS:1] vld_s;
	logic sk_vld_q;
	logic [3*W-1:0] sk_data_q;

	logic signed [W-1:0]   pt_s1 [4][3];
	logic signed [W-1:0]   abc_s [2:15][3][3];
	logic signed [DFW-1:0] diff_s2 [6][3];
	logic signed [DFW-1:0] dir_s [3:15][3][3];
	logic signed [PDW-1:0] dprod [6][3];
	logic signed [DW-1:0]  d_s8 [6];
	logic signed [DW-1:0]  dd_s [9:15][2];
	logic signed [DW:0]    e1_s9, e2_s9, dab_s9, dac_s9;
	logic [3:0]            dn_s9, dz_s9;
	flag_t                 fl_s [10:15];
	edg_t                  eg_s [10:15];
	logic signed [2*DW-1:0] vprod [6];
	logic signed [VW-1:0]  va_s14, vb_s14, vc_s14, vb_s15, vc_s15;
	logic signed [DENW-1:0] den_i_s15;
	logic [2:0]            vle_s15;

	logic signed [W-1:0]    sel_start [3];
	logic signed [VW-1:0]   sel_n1, sel_n2;
	logic signed [DFW-1:0]  sel_dir1 [3];
	logic signed [DENW-1:0] sel_den;

	logic signed [W-1:0]    start_s [16:OS-1][3];
	logic signed [VW-1:0]   n1_s16, n2_s16;
	logic signed [DFW-1:0]  dir1_s16 [3];
	logic signed [DFW-1:0]  dir2_s16 [3];
	logic signed [DENW-1:0] den_s [16:22];
	logic signed [PW-1:0]   m1 [3];
	logic signed [PW-1:0]   m2 [3];
	logic signed [NW-1:0]   num_s22 [3];
	logic signed [QK:0]     qv [3];
	logic signed [SW-1:0]   sum_c [3];
	logic [3*W-1:0]         res_c;
	logic [3*W-1:0]         near_s [OS:OS];

	assign en       = !sk_vld_q;
	assign s_tready = en;
	assign m_tvalid = sk_vld_q || vld_s[OS];
	assign m_tdata  = OUT_W'(sk_vld_q ? sk_data_q : near_s[OS]);

	// coordinates in, edge and query vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				for (int k = 0; k < 3; k++)
					pt_s1[i][k] <= s_tdata[(3*i+k)*W +: W];
			for (int k = 0; k < 3; k++) begin
				diff_s2[0][k] <= DFW'(pt_s1[2][k]) - DFW'(pt_s1[1][k]);
				diff_s2[1][k] <= DFW'(pt_s1[3][k]) - DFW'(pt_s1[1][k]);
				diff_s2[2][k] <= DFW'(pt_s1[3][k]) - DFW'(pt_s1[2][k]);
				diff_s2[3][k] <= DFW'(pt_s1[0][k]) - DFW'(pt_s1[1][k]);
				diff_s2[4][k] <= DFW'(pt_s1[0][k]) - DFW'(pt_s1[2][k]);
				diff_s2[5][k] <= DFW'(pt_s1[0][k]) - DFW'(pt_s1[3][k]);
			end
			for (int v = 0; v < 3; v++)
				for (int k = 0; k < 3; k++) begin
					abc_s[2][v][k] <= pt_s1[v+1][k];
					dir_s[3][v][k] <= diff_s2[v][k];
				end
			for (int s = 3; s <= 15; s++)
				abc_s[s] <= abc_s[s-1];
			for (int s = 4; s <= 15; s++)
				dir_s[s] <= dir_s[s-1];
		end
	end

	// d1..d6: ab or ac against ap, bp, cp
	for (genvar gm = 0; gm < 6; gm++) begin : g_dot
		for (genvar gk = 0; gk < 3; gk++) begin : g_axis
			cpt_mul #(.A_W(DFW), .B_W(DFW)) u_mul (
				.clk (clk),
				.en  (en),
				.a   (diff_s2[gm % 2][gk]),
				.b   (diff_s2[3 + gm / 2][gk]),
				.p   (dprod[gm][gk])
			);
		end
	end

	for (genvar gv = 0; gv < 6; gv++) begin : g_bary
		cpt_mul #(.A_W(DW), .B_W(DW)) u_mul (
			.clk (clk),
			.en  (en),
			.a   (d_s8[VA_I[gv]]),
			.b   (d_s8[VB_I[gv]]),
			.p   (vprod[gv])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 6; m++)
				d_s8[m] <= DW'(dprod[m][0]) + DW'(dprod[m][1]) + DW'(dprod[m][2]);

			e1_s9  <= (DW+1)'(d_s8[3]) - (DW+1)'(d_s8[2]);
			e2_s9  <= (DW+1)'(d_s8[4]) - (DW+1)'(d_s8[5]);
			dab_s9 <= (DW+1)'(d_s8[0]) - (DW+1)'(d_s8[2]);
			dac_s9 <= (DW+1)'(d_s8[1]) - (DW+1)'(d_s8[5]);
			dn_s9  <= {d_s8[5][DW-1], d_s8[2][DW-1], d_s8[1][DW-1], d_s8[0][DW-1]};
			dz_s9  <= {d_s8[5] == '0, d_s8[2] == '0, d_s8[1] == '0, d_s8[0] == '0};
			dd_s[9][0] <= d_s8[0];
			dd_s[9][1] <= d_s8[1];
			for (int s = 10; s <= 15; s++)
				dd_s[s] <= dd_s[s-1];

			fl_s[10].pa  <= (dn_s9[0] || dz_s9[0]) && (dn_s9[1] || dz_s9[1]);
			fl_s[10].pb  <= !dn_s9[2] && (e1_s9[DW] || e1_s9 == '0);
			fl_s[10].pc  <= !dn_s9[3] && (e2_s9[DW] || e2_s9 == '0);
			fl_s[10].eab <= !dn_s9[0] && (dn_s9[2] || dz_s9[2]);
			fl_s[10].eac <= !dn_s9[1] && (dn_s9[3] || dz_s9[3]);
			fl_s[10].ebc <= !e1_s9[DW] && !e2_s9[DW];
			eg_s[10].e1  <= e1_s9;
			eg_s[10].dab <= dab_s9;
			eg_s[10].dac <= dac_s9;
			eg_s[10].dbc <= (DW+2)'(e1_s9) + (DW+2)'(e2_s9);
			for (int s = 11; s <= 15; s++) begin
				fl_s[s] <= fl_s[s-1];
				eg_s[s] <= eg_s[s-1];
			end

			vc_s14 <= VW'(vprod[0]) - VW'(vprod[1]);
			vb_s14 <= VW'(vprod[2]) - VW'(vprod[3]);
			va_s14 <= VW'(vprod[4]) - VW'(vprod[5]);

			den_i_s15 <= DENW'(va_s14) + DENW'(vb_s14) + DENW'(vc_s14);
			vb_s15    <= vb_s14;
			vc_s15    <= vc_s14;
			vle_s15   <= {vc_s14[VW-1] || vc_s14 == '0, vb_s14[VW-1] || vb_s14 == '0,
				va_s14[VW-1] || va_s14 == '0};
		end
	end

	// region pick: vertices, then edges ab, ac, bc, then vertex a for a degenerate triangle, else interior
	always_comb begin
		sel_start = abc_s[15][0];
		sel_n1    = '0;
		sel_n2    = '0;
		sel_dir1  = dir_s[15][0];
		sel_den   = '0;
		priority if (fl_s[15].pa) begin
			sel_start = abc_s[15][0];
		end else if (fl_s[15].pb) begin
			sel_start = abc_s[15][1];
		end else if (fl_s[15].pc) begin
			sel_start = abc_s[15][2];
		end else if (vle_s15[2] && fl_s[15].eab) begin
			sel_n1  = VW'(dd_s[15][0]);
			sel_den = DENW'(eg_s[15].dab);
		end else if (vle_s15[1] && fl_s[15].eac) begin
			sel_n1   = VW'(dd_s[15][1]);
			sel_dir1 = dir_s[15][1];
			sel_den  = DENW'(eg_s[15].dac);
		end else if (vle_s15[0] && fl_s[15].ebc) begin
			sel_start = abc_s[15][1];
			sel_n1    = VW'(eg_s[15].e1);
			sel_dir1  = dir_s[15][2];
			sel_den   = DENW'(eg_s[15].dbc);
		end else if (den_i_s15 == '0) begin
			sel_start = abc_s[15][0];
		end else begin
			sel_n1  = vb_s15;
			sel_n2  = vc_s15;
			sel_den = den_i_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			start_s[16] <= sel_start;
			n1_s16      <= sel_n1;
			n2_s16      <= sel_n2;
			dir1_s16    <= sel_dir1;
			dir2_s16    <= dir_s[15][1];
			den_s[16]   <= sel_den;
			for (int s = 17; s <= 22; s++)
				den_s[s] <= den_s[s-1];
			for (int s = 17; s <= OS - 1; s++)
				start_s[s] <= start_s[s-1];
			for (int k = 0; k < 3; k++)
				num_s22[k] <= NW'(m1[k]) + NW'(m2[k]);
			near_s[OS] <= res_c;
		end
	end

	for (genvar gk = 0; gk < 3; gk++) begin : g_lane
		cpt_mul #(.A_W(VW), .B_W(DFW)) u_mul1 (
			.clk (clk),
			.en  (en),
			.a   (n1_s16),
			.b   (dir1_s16[gk]),
			.p   (m1[gk])
		);

		cpt_mul #(.A_W(VW), .B_W(DFW)) u_mul2 (
			.clk (clk),
			.en  (en),
			.a   (n2_s16),
			.b   (dir2_s16[gk]),
			.p   (m2[gk])
		);

		cpt_div #(.NUM_W(NW), .DEN_W(DENW), .QUO_W(QK)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s22[gk]),
			.den (den_s[22]),
			.quo (qv[gk])
		);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = SW'(start_s[OS-1][k]) + SW'(qv[k]);
			if (sum_c[k] > SMAX)
				res_c[k*W +: W] = SMAX[W-1:0];
			else if (sum_c[k] < SMIN)
				res_c[k*W +: W] = SMIN[W-1:0];
			else
				res_c[k*W +: W] = sum_c[k][W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s    <= '0;
			sk_vld_q <= 1'b0;
		end else begin
			if (en)
				vld_s <= {vld_s[OS-1:1], s_tvalid};
			if (sk_vld_q) begin
				if (m_tready)
					sk_vld_q <= 1'b0;
			end else if (vld_s[OS] && !m_tready) begin
				sk_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_vld_q)
			sk_data_q <= near_s[OS];
	end

	`CPT_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(vld_s))
	`CPT_ASSERT_NOW(a_skid_fills_on_stall, $rose(sk_vld_q), $past(vld_s[OS]) && !$past(m_tready))
	`CPT_ASSERT_NEXT(a_skid_keeps_item, sk_vld_q && !m_tready, sk_vld_q && $stable(sk_data_q))
endmodule

`default_nettype wire

### design/cpt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module cpt_mul #(
	parameter int A_W = 33,
	parameter int B_W = 33
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [A_W-1:0]     a,
	input  logic signed [B_W-1:0]     b,
	output logic signed [A_W+B_W-1:0] p
);
	localparam int LW  = cpt_pkg::LIMB_W;
	localparam int NA  = (A_W + LW - 1) / LW;
	localparam int NB  = (B_W + LW - 1) / LW;
	localparam int AP  = NA * LW;
	localparam int BP  = NB * LW;
	localparam int PPW = 2 * LW;
	localparam int RW  = (NB + 1) * LW;
	localparam int TW  = (NA + NB) * LW;
	localparam int PW  = A_W + B_W;

	logic [A_W-1:0] am_c;
	logic [B_W-1:0] bm_c;
	logic [AP-1:0]  ma_s1;
	logic [BP-1:0]  mb_s1;
	logic           sg_s1, sg_s2, sg_s3, sg_s4;
	logic [PPW-1:0] pp_s2 [NA][NB];
	logic [RW-1:0]  row_c [NA];
	logic [RW-1:0]  row_s3 [NA];
	logic [TW-1:0]  tot_c;
	logic [PW-1:0]  mag_s4;

	assign am_c = a[A_W-1] ? (~a + 1'b1) : a;
	assign bm_c = b[B_W-1] ? (~b + 1'b1) : b;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++)
				row_c[i] = row_c[i] + (RW'(pp_s2[i][j]) << (j * LW));
		end
	end

	always_comb begin
		tot_c = '0;
		for (int i = 0; i < NA; i++)
			tot_c = tot_c + (TW'(row_s3[i]) << (i * LW));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= AP'(am_c);
			mb_s1 <= BP'(bm_c);
			sg_s1 <= a[A_W-1] ^ b[B_W-1];
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s2[i][j] <= PPW'(ma_s1[i*LW +: LW]) * PPW'(mb_s1[j*LW +: LW]);
			sg_s2  <= sg_s1;
			row_s3 <= row_c;
			sg_s3  <= sg_s2;
			mag_s4 <= tot_c[PW-1:0];
			sg_s4  <= sg_s3;
			p      <= sg_s4 ? (~mag_s4 + 1'b1) : mag_s4;
		end
	end
endmodule

`default_nettype wire

### design/cpt_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cpt_div #(
	parameter int NUM_W = 171,
	parameter int DEN_W = 139,
	parameter int QUO_W = 34
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic signed [QUO_W:0]   quo
);
	localparam int CW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

	logic [NUM_W-1:0] nm_c;
	logic [DEN_W-1:0] dm_c;
	logic [NUM_W-1:0] nm_s1;
	logic [DEN_W-1:0] dm_s1;
	logic             neg_s1, dz_s1;
	logic [CW-1:0]    rem_s [QUO_W+1];
	logic [DEN_W-1:0] dm_s  [QUO_W+1];
	logic [QUO_W-1:0] q_s   [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             ov_s  [QUO_W+1];
	logic             dz_s  [QUO_W+1];
	logic [QUO_W:0]   qz;

	assign nm_c = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign dm_c = den[DEN_W-1] ? (~den + 1'b1) : den;

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s1    <= nm_c;
			dm_s1    <= dm_c;
			neg_s1   <= num[NUM_W-1] ^ den[DEN_W-1];
			dz_s1    <= den == '0;
			rem_s[0] <= CW'(nm_s1);
			dm_s[0]  <= dm_s1;
			q_s[0]   <= '0;
			neg_s[0] <= neg_s1;
			dz_s[0]  <= dz_s1;
			// quotient too large for the result range
			ov_s[0]  <= !dz_s1 && (CW'(nm_s1) >= (CW'(dm_s1) << QUO_W));
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_step
		logic [CW-1:0] dsh;
		logic          take;

		assign dsh  = CW'(dm_s[g]) << (QUO_W - 1 - g);
		assign take = rem_s[g] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= take ? (rem_s[g] - dsh) : rem_s[g];
				q_s[g+1]   <= {q_s[g][QUO_W-2:0], take};
				dm_s[g+1]  <= dm_s[g];
				neg_s[g+1] <= neg_s[g];
				ov_s[g+1]  <= ov_s[g];
				dz_s[g+1]  <= dz_s[g];
			end
		end
	end

	assign qz = {1'b0, q_s[QUO_W]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s[QUO_W])
				quo <= '0;
			else if (ov_s[QUO_W])
				quo <= {neg_s[QUO_W], {QUO_W{~neg_s[QUO_W]}}};
			else
				quo <= neg_s[QUO_W] ? (~qz + 1'b1) : qz;
		end
	end
endmodule

`default_nettype wire
